>>> hw/rtl/bqe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqe_pkg
// Shared constants, types and helpers for the billboard quad expansion block.
// ----------------------------------------------------------------------------
package bqe_pkg;

    localparam int UNIT_SHIFT   = 30;
    localparam int ISQRT_STAGES = 16;
    localparam int DIV_STAGES   = 16;
    // front (5) + square root + divide + sign stage
    localparam int NORM_LAT     = 5 + ISQRT_STAGES + DIV_STAGES + 1;

    localparam logic [1:0] REG_CAM_X = 2'd0;
    localparam logic [1:0] REG_CAM_Y = 2'd1;
    localparam logic [1:0] REG_CAM_Z = 2'd2;

    typedef logic [2:0][63:0] wvec_t;
    typedef logic [2:0][31:0] uvec_t;

    // magnitude of a Q2.30 unit part
    function automatic logic [30:0] unit_mag(input logic [31:0] u);
        logic [31:0] n;
        n = ~u + 32'd1;
        return u[31] ? n[30:0] : u[30:0];
    endfunction

    // round |unit|*size half away from zero by 2^31, then restore the sign
    function automatic logic [31:0] round_half(input logic [61:0] prod, input logic neg);
        logic [61:0] s;
        logic [31:0] r;
        s = prod + (62'd1 << UNIT_SHIFT);
        r = {1'b0, s[61:UNIT_SHIFT+1]};
        return neg ? ~r + 32'd1 : r;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/billboard_quad_expansion.sv
`default_nettype none
// ----------------------------------------------------------------------------
// billboard_quad_expansion
// Expands one billboard into its four camera-facing corners, Q16.16.
// A start is taken only while busy is low; busy is held high by a down-counter
//   loaded on each taken start. The result port sends one word per cycle.
// The pipeline itself never stalls; the receiver must take every word, as there is no ready input.
// Reset clears the valid bits, the busy counter and the camera registers.
// ----------------------------------------------------------------------------
module billboard_quad_expansion (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  center_x,
    input  logic signed [31:0]  center_y,
    input  logic signed [31:0]  center_z,
    input  logic [30:0]         width,
    input  logic [30:0]         height,
    input  logic                horizontal,
    output logic                valid,
    output logic [1:0]          corner,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [31:0]  pos_z,
    output logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int NL = bqe_pkg::NORM_LAT;

    typedef struct packed {
        bqe_pkg::uvec_t c;
        logic [30:0]    w;
        logic [30:0]    h;
    } side1_t;

    typedef struct packed {
        bqe_pkg::uvec_t c;
        bqe_pkg::uvec_t ha;
        logic [30:0]    h;
    } side2_t;

    logic [31:0]      cam_x_reg, cam_y_reg, cam_z_reg;
    logic [1:0]       busy_cnt_reg, busy_cnt_next;
    logic             accept;

    logic             t1_vld_reg;
    bqe_pkg::wvec_t   t1_d_reg, t1_d_next, t1_a_reg, t1_a_next;
    side1_t           t1_side_reg;
    side1_t           dl1_reg [NL];

    logic             na_vld, nd_vld;
    bqe_pkg::uvec_t   an, dn;

    logic             t2_vld_reg;
    logic signed [63:0] t2_p_reg [4];
    logic [2:0][61:0] t2_hamag_reg;
    logic [2:0]       t2_haneg_reg;
    bqe_pkg::uvec_t   t2_c_reg;
    logic [30:0]      t2_h_reg;

    logic             t3_vld_reg;
    bqe_pkg::wvec_t   t3_b_reg;
    side2_t           t3_side_reg;
    side2_t           dl2_reg [NL];

    logic             nb_vld;
    bqe_pkg::uvec_t   bn;

    logic             t4_vld_reg;
    logic [2:0][61:0] t4_hbmag_reg;
    logic [2:0]       t4_hbneg_reg;
    bqe_pkg::uvec_t   t4_c_reg, t4_ha_reg;

    logic             t5_vld_reg;
    bqe_pkg::uvec_t   t5_c_reg, t5_ha_reg, t5_hb_reg;

    assign accept    = start && !busy;
    assign busy      = (busy_cnt_reg != 2'd0);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        busy_cnt_next = busy_cnt_reg;
        if (accept)
        begin
            busy_cnt_next = 2'd3;
        end
        else if (busy_cnt_reg != 2'd0)
        begin
            busy_cnt_next = busy_cnt_reg - 2'd1;
        end
    end

    // view vector and view x up = (-dz, 0, dx)
    always_comb
    begin
        t1_d_next[0] = {{32{center_x[31]}}, center_x} - {{32{cam_x_reg[31]}}, cam_x_reg};
        t1_d_next[1] = horizontal ? 64'd0
                     : {{32{center_y[31]}}, center_y} - {{32{cam_y_reg[31]}}, cam_y_reg};
        t1_d_next[2] = {{32{center_z[31]}}, center_z} - {{32{cam_z_reg[31]}}, cam_z_reg};
        t1_a_next[0] = ~t1_d_next[2] + 64'd1;
        t1_a_next[1] = '0;
        t1_a_next[2] = t1_d_next[0];
    end

    always_ff @(posedge clk)
    begin
        t1_d_reg      <= t1_d_next;
        t1_a_reg      <= t1_a_next;
        t1_side_reg.c <= {center_z, center_y, center_x};
        t1_side_reg.w <= width;
        t1_side_reg.h <= height;
        dl1_reg[0]    <= t1_side_reg;
        for (int k = 1; k < NL; k++)
        begin
            dl1_reg[k] <= dl1_reg[k-1];
        end
    end

    bqe_norm u_norm_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t1_vld_reg),
        .vec       (t1_a_reg),
        .out_valid (na_vld),
        .unit_vec  (an)
    );

    bqe_norm u_norm_d (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t1_vld_reg),
        .vec       (t1_d_reg),
        .out_valid (nd_vld),
        .unit_vec  (dn)
    );

    // cross product terms (the up-axis part of the A unit is always zero)
    always_ff @(posedge clk)
    begin
        t2_p_reg[0] <= $signed(dn[1]) * $signed(an[2]);
        t2_p_reg[1] <= $signed(dn[2]) * $signed(an[0]);
        t2_p_reg[2] <= $signed(dn[0]) * $signed(an[2]);
        t2_p_reg[3] <= $signed(dn[1]) * $signed(an[0]);
        for (int i = 0; i < 3; i++)
        begin
            t2_hamag_reg[i] <= bqe_pkg::unit_mag(an[i]) * dl1_reg[NL-1].w;
            t2_haneg_reg[i] <= an[i][31];
        end
        t2_c_reg <= dl1_reg[NL-1].c;
        t2_h_reg <= dl1_reg[NL-1].h;
    end

    always_ff @(posedge clk)
    begin
        t3_b_reg[0] <= t2_p_reg[0];
        t3_b_reg[1] <= t2_p_reg[1] - t2_p_reg[2];
        t3_b_reg[2] <= -t2_p_reg[3];
        for (int i = 0; i < 3; i++)
        begin
            t3_side_reg.ha[i] <= bqe_pkg::round_half(t2_hamag_reg[i], t2_haneg_reg[i]);
        end
        t3_side_reg.c <= t2_c_reg;
        t3_side_reg.h <= t2_h_reg;
        dl2_reg[0]    <= t3_side_reg;
        for (int k = 1; k < NL; k++)
        begin
            dl2_reg[k] <= dl2_reg[k-1];
        end
    end

    bqe_norm u_norm_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t3_vld_reg),
        .vec       (t3_b_reg),
        .out_valid (nb_vld),
        .unit_vec  (bn)
    );

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            t4_hbmag_reg[i] <= bqe_pkg::unit_mag(bn[i]) * dl2_reg[NL-1].h;
            t4_hbneg_reg[i] <= bn[i][31];
            t5_hb_reg[i]    <= bqe_pkg::round_half(t4_hbmag_reg[i], t4_hbneg_reg[i]);
        end
        t4_c_reg  <= dl2_reg[NL-1].c;
        t4_ha_reg <= dl2_reg[NL-1].ha;
        t5_c_reg  <= t4_c_reg;
        t5_ha_reg <= t4_ha_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg    <= '0;
            cam_y_reg    <= '0;
            cam_z_reg    <= '0;
            busy_cnt_reg <= '0;
            t1_vld_reg   <= 1'b0;
            t2_vld_reg   <= 1'b0;
            t3_vld_reg   <= 1'b0;
            t4_vld_reg   <= 1'b0;
            t5_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    bqe_pkg::REG_CAM_X: cam_x_reg <= cfg_data;
                    bqe_pkg::REG_CAM_Y: cam_y_reg <= cfg_data;
                    bqe_pkg::REG_CAM_Z: cam_z_reg <= cfg_data;
                    default:            ;
                endcase
            end
            busy_cnt_reg <= busy_cnt_next;
            t1_vld_reg   <= accept;
            t2_vld_reg   <= na_vld && nd_vld;
            t3_vld_reg   <= t2_vld_reg;
            t4_vld_reg   <= nb_vld;
            t5_vld_reg   <= t4_vld_reg;
        end
    end

    bqe_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (t5_vld_reg),
        .center   (t5_c_reg),
        .half_a   (t5_ha_reg),
        .half_b   (t5_hb_reg),
        .valid    (valid),
        .corner   (corner),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .last     (last)
    );

endmodule
`default_nettype wire

>>> hw/rtl/bqe_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqe_isqrt
// Pipelined floor square root of a 64-bit word, two root bits per stage.
// ----------------------------------------------------------------------------
module bqe_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [63:0] radicand,
    output logic        out_valid,
    output logic [31:0] root
);

    localparam int N = bqe_pkg::ISQRT_STAGES;

    logic [N-1:0] vld_reg;
    logic [33:0]  rem_reg  [N];
    logic [31:0]  root_reg [N];
    logic [63:0]  rad_reg  [N];

    function automatic logic [65:0] sqrt_step(input logic [33:0] rem, input logic [31:0] rt,
                                              input logic [1:0] pair);
        logic [33:0] r2;
        logic [33:0] t;
        r2 = {rem[31:0], pair};
        t  = {rt, 2'b01};
        if (r2 >= t)
        begin
            return {r2 - t, rt[30:0], 1'b1};
        end
        return {r2, rt[30:0], 1'b0};
    endfunction

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [33:0] rem_in;
        logic [31:0] rt_in;
        logic [63:0] rad_in;
        logic [65:0] st1;
        logic [65:0] st2;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign rt_in  = '0;
            assign rad_in = radicand;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign rt_in  = root_reg[s-1];
            assign rad_in = rad_reg[s-1];
        end

        assign st1 = sqrt_step(rem_in, rt_in, rad_in[63:62]);
        assign st2 = sqrt_step(st1[65:32], st1[31:0], rad_in[61:60]);

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= st2[65:32];
            root_reg[s] <= st2[31:0];
            rad_reg[s]  <= {rad_in[59:0], 4'b0000};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1];

endmodule
`default_nettype wire

>>> hw/rtl/bqe_norm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqe_norm
// Pipelined fixed-point normalize of a 3-vector to a Q2.30 unit vector.
// ----------------------------------------------------------------------------
module bqe_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  bqe_pkg::wvec_t      vec,
    output logic                out_valid,
    output bqe_pkg::uvec_t      unit_vec
);

    localparam int NS = bqe_pkg::ISQRT_STAGES;
    localparam int ND = bqe_pkg::DIV_STAGES;

    typedef struct packed {
        logic [2:0][30:0] mag;
        logic [2:0]       neg;
        logic             zero;
    } nside_t;

    // front stages
    logic             s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic [2:0][63:0] s1_mag_reg, s1_mag_next, s2_mag_reg;
    logic [2:0]       s1_neg_reg, s1_neg_next, s2_neg_reg;
    logic             s2_zero_reg, s2_zero_next, s2_left_reg, s2_left_next;
    logic [5:0]       s2_amt_reg, s2_amt_next;
    nside_t           s3_reg, s3_next, s4_reg, s5_reg;
    logic [2:0][61:0] s4_sq_reg;
    logic [63:0]      s5_sum_reg;

    // side data beside the square root
    nside_t           dly_reg [NS];
    logic             sq_vld;
    logic [31:0]      sq_root;

    // divide stages
    logic [ND-1:0]    dv_vld_reg;
    logic [2:0][32:0] dv_rem_reg [ND];
    logic [2:0][30:0] dv_q_reg   [ND];
    logic [31:0]      dv_len_reg [ND];
    logic [2:0]       dv_neg_reg [ND];
    logic             dv_zero_reg [ND];

    logic             out_vld_reg;
    bqe_pkg::uvec_t   u_reg, u_next;

    function automatic logic [33:0] div_step(input logic [32:0] rem, input logic [31:0] len);
        logic        ge;
        logic [32:0] r;
        ge = rem >= {1'b0, len};
        r  = ge ? rem - {1'b0, len} : rem;
        return {ge, r[31:0], 1'b0};
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_neg_next[i] = vec[i][63];
            s1_mag_next[i] = vec[i][63] ? ~vec[i] + 64'd1 : vec[i];
        end
    end

    // leading one of the largest part is the leading one of the OR
    always_comb
    begin
        logic [63:0] all_bits;
        logic [5:0]  p;
        all_bits = s1_mag_reg[0] | s1_mag_reg[1] | s1_mag_reg[2];
        p = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (all_bits[i])
            begin
                p = 6'(i);
            end
        end
        s2_zero_next = (all_bits == '0);
        s2_left_next = (p < 6'(bqe_pkg::UNIT_SHIFT));
        s2_amt_next  = s2_left_next ? 6'(bqe_pkg::UNIT_SHIFT) - p : p - 6'(bqe_pkg::UNIT_SHIFT);
    end

    always_comb
    begin
        logic [63:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            sh = s2_left_reg ? (s2_mag_reg[i] << s2_amt_reg) : (s2_mag_reg[i] >> s2_amt_reg);
            s3_next.mag[i] = sh[30:0];
        end
        s3_next.neg  = s2_neg_reg;
        s3_next.zero = s2_zero_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_mag_reg  <= s1_mag_next;
        s1_neg_reg  <= s1_neg_next;
        s2_mag_reg  <= s1_mag_reg;
        s2_neg_reg  <= s1_neg_reg;
        s2_zero_reg <= s2_zero_next;
        s2_left_reg <= s2_left_next;
        s2_amt_reg  <= s2_amt_next;
        s3_reg      <= s3_next;
        s4_reg      <= s3_reg;
        for (int i = 0; i < 3; i++)
        begin
            s4_sq_reg[i] <= s3_reg.mag[i] * s3_reg.mag[i];
        end
        s5_reg      <= s4_reg;
        s5_sum_reg  <= {2'b00, s4_sq_reg[0]} + {2'b00, s4_sq_reg[1]} + {2'b00, s4_sq_reg[2]};
        dly_reg[0]  <= s5_reg;
        for (int k = 1; k < NS; k++)
        begin
            dly_reg[k] <= dly_reg[k-1];
        end
    end

    bqe_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_vld_reg),
        .radicand  (s5_sum_reg),
        .out_valid (sq_vld),
        .root      (sq_root)
    );

    for (genvar s = 0; s < ND; s++)
    begin : g_div
        logic [2:0][32:0] rem_in, rem_next;
        logic [2:0][30:0] q_in, q_next;
        logic [31:0]      len_in;
        logic [2:0]       neg_in;
        logic             zero_in;

        if (s == 0)
        begin : g_first
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_in[i] = {2'b00, dly_reg[NS-1].mag[i]};
                end
            end
            assign q_in    = '0;
            assign len_in  = sq_root;
            assign neg_in  = dly_reg[NS-1].neg;
            assign zero_in = dly_reg[NS-1].zero;
        end
        else
        begin : g_rest
            assign rem_in  = dv_rem_reg[s-1];
            assign q_in    = dv_q_reg[s-1];
            assign len_in  = dv_len_reg[s-1];
            assign neg_in  = dv_neg_reg[s-1];
            assign zero_in = dv_zero_reg[s-1];
        end

        always_comb
        begin
            logic [33:0] x1;
            logic [33:0] x2;
            for (int i = 0; i < 3; i++)
            begin
                x1 = div_step(rem_in[i], len_in);
                x2 = div_step(x1[32:0], len_in);
                if (s == ND - 1)
                begin
                    q_next[i]   = {q_in[i][29:0], x1[33]};
                    rem_next[i] = x1[32:0];
                end
                else
                begin
                    q_next[i]   = {q_in[i][28:0], x1[33], x2[33]};
                    rem_next[i] = x2[32:0];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[s]  <= rem_next;
            dv_q_reg[s]    <= q_next;
            dv_len_reg[s]  <= len_in;
            dv_neg_reg[s]  <= neg_in;
            dv_zero_reg[s] <= zero_in;
        end
    end

    always_comb
    begin
        logic [31:0] q;
        for (int i = 0; i < 3; i++)
        begin
            q = {1'b0, dv_q_reg[ND-1][i]};
            if (dv_zero_reg[ND-1])
            begin
                u_next[i] = '0;
            end
            else
            begin
                u_next[i] = dv_neg_reg[ND-1][i] ? ~q + 32'd1 : q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            dv_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= in_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            dv_vld_reg  <= {dv_vld_reg[ND-2:0], sq_vld};
            out_vld_reg <= dv_vld_reg[ND-1];
        end
    end

    assign out_valid = out_vld_reg;
    assign unit_vec  = u_reg;

endmodule
`default_nettype wire

>>> hw/rtl/bqe_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqe_emit
// Corner sequencer: one saturated corner word per cycle, four per billboard.
// ----------------------------------------------------------------------------
module bqe_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  bqe_pkg::uvec_t      center,
    input  bqe_pkg::uvec_t      half_a,
    input  bqe_pkg::uvec_t      half_b,
    output logic                valid,
    output logic [1:0]          corner,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [31:0]  pos_z,
    output logic                last
);

    bqe_pkg::uvec_t c_reg, a_reg, b_reg;
    logic           active_reg, active_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           vld_reg;
    logic [1:0]     corner_reg;
    logic           last_reg;
    bqe_pkg::uvec_t pos_reg, pos_next;

    function automatic logic [31:0] sat32(input logic [33:0] v);
        if (v[33] == 1'b0 && v[32:31] != 2'b00)
        begin
            return 32'h7FFF_FFFF;
        end
        if (v[33] == 1'b1 && v[32:31] != 2'b11)
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    always_comb
    begin
        logic        a_sub;
        logic        b_sub;
        logic [33:0] cx, ax, bx;
        a_sub = 1'b0;
        b_sub = 1'b0;
        case (cnt_reg)
            2'd0:    begin a_sub = 1'b0; b_sub = 1'b1; end
            2'd1:    begin a_sub = 1'b1; b_sub = 1'b1; end
            2'd2:    begin a_sub = 1'b1; b_sub = 1'b0; end
            default: begin a_sub = 1'b0; b_sub = 1'b0; end
        endcase
        for (int i = 0; i < 3; i++)
        begin
            cx = {{2{c_reg[i][31]}}, c_reg[i]};
            ax = {{2{a_reg[i][31]}}, a_reg[i]};
            bx = {{2{b_reg[i][31]}}, b_reg[i]};
            pos_next[i] = sat32(cx + (a_sub ? ~ax + 34'd1 : ax) + (b_sub ? ~bx + 34'd1 : bx));
        end
    end

    always_comb
    begin
        active_next = active_reg && (cnt_reg != 2'd3);
        cnt_next    = cnt_reg + 2'd1;
        // a new billboard may land on the edge that sends the last corner
        if (in_valid)
        begin
            active_next = 1'b1;
            cnt_next    = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            c_reg <= center;
            a_reg <= half_a;
            b_reg <= half_b;
        end
        pos_reg    <= pos_next;
        corner_reg <= cnt_reg;
        last_reg   <= (cnt_reg == 2'd3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            vld_reg    <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            vld_reg    <= active_reg;
        end
    end

    assign valid  = vld_reg;
    assign corner = corner_reg;
    assign last   = last_reg;
    assign pos_x  = pos_reg[0];
    assign pos_y  = pos_reg[1];
    assign pos_z  = pos_reg[2];

endmodule
`default_nettype wire
